// ===== sv/pvsc_pkg.sv =====
package pvsc_pkg;

  // Operating modes
  typedef enum logic [1:0] {
    MODE_HAND  = 2'd0,
    MODE_HYST  = 2'd1,
    MODE_LOOP  = 2'd2,
    MODE_SPARE = 2'd3
  } mode_e;

  // Item kinds
  typedef enum logic [2:0] {
    KIND_SAMPLE = 3'd0,
    KIND_PUMP   = 3'd1,
    KIND_VALVE  = 3'd2,
    KIND_RAMP   = 3'd3,
    KIND_TICK   = 3'd4
  } kind_e;

  // Shutdown causes, in priority order
  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_ESTOP = 2'd1,
    CAUSE_OVERI = 2'd2,
    CAUSE_OVERT = 2'd3
  } cause_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_MODE        = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TARGET      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BAND        = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CURRENT     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TEMPERATURE = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_FLOOR       = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_CEILING     = 3'd6;

  localparam int unsigned CfgDataW = 16;

  // Fixed constants of the control law
  localparam logic [7:0]  AUTO_DUTY   = 8'd200;
  localparam logic [15:0] MIN_STEP_MS = 16'd10;

  // Divider: 16-bit dividend, one quotient bit per cycle
  localparam int unsigned DivSteps = 16;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] pressure;
    logic [15:0]        current_ma;
    logic signed [15:0] temperature;
    logic               estop;
    logic               enable;
    logic [7:0]         duty;
    logic [15:0]        ramp_ms;
  } in_item_t;

  typedef struct packed {
    logic       pump_on;
    logic [7:0] pump_duty;
    logic       valve_on;
    logic       main_supply;
    logic       emergency_supply;
    logic [1:0] shutdown_cause;
    logic       pid_reset;
    logic       refused;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_step;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_EVAL   = 2'd1,
    ST_DIV    = 2'd2,
    ST_COMMIT = 2'd3
  } state_e;

endpackage

// ===== sv/pvsc_if.sv =====
interface pvsc_in_if;
  logic               valid;
  logic               ready;
  pvsc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pvsc_out_if;
  logic                valid;
  logic                ready;
  pvsc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pvsc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [pvsc_pkg::CfgIdxW-1:0]        index;
  logic [pvsc_pkg::CfgDataW-1:0]       data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/pvsc_ctrl.sv =====
module pvsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  pvsc_pkg::dp_sts_t sts_i,
  output pvsc_pkg::dp_cmd_t cmd_o
);
  import pvsc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // Result slot can take a new transaction when empty or draining now
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_EVAL;
      ST_EVAL:   state_d = sts_i.need_div ? ST_DIV : ST_COMMIT;
      ST_DIV:    if (sts_i.div_last) state_d = ST_COMMIT;
      ST_COMMIT: if (slot_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EVAL:   cmd_o.div_start = sts_i.need_div;
      ST_DIV:    cmd_o.div_step  = 1'b1;
      ST_COMMIT: cmd_o.commit    = slot_free;
      default: ;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/pvsc_dp.sv =====
module pvsc_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pvsc_pkg::dp_cmd_t               cmd_i,
  output pvsc_pkg::dp_sts_t               sts_o,
  input  pvsc_pkg::in_item_t              item_i,
  input  logic                            cfg_write_i,
  input  logic [pvsc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pvsc_pkg::CfgDataW-1:0]   cfg_data_i,
  output pvsc_pkg::out_item_t             result_o
);
  import pvsc_pkg::*;

  // Configuration registers
  logic [1:0]         mode_q;
  logic signed [15:0] target_q;
  logic [14:0]        band_q;
  logic [15:0]        cur_trip_q;
  logic signed [15:0] temp_trip_q;
  logic [7:0]         floor_q;
  logic [7:0]         ceil_q;

  // Controller state
  logic        pump_q, pump_d;
  logic        valve_q, valve_d;
  logic [7:0]  duty_q, duty_d;
  logic        main_q, main_d;
  logic        emerg_q, emerg_d;
  logic        busy_q, busy_d;
  logic [7:0]  goal_q, goal_d;
  logic        rising_q, rising_d;
  logic [15:0] interval_q, interval_d;
  logic [15:0] ms_q, ms_d;

  // Item, divider and result registers
  in_item_t    item_q;
  logic [7:0]  rem_q;
  logic [15:0] quo_q;
  logic [DivCntW-1:0] cnt_q;
  out_item_t   result_q, result_d;

  function automatic logic [7:0] clamp_duty(input logic [7:0] d,
                                            input logic [7:0] lo,
                                            input logic [7:0] hi);
    logic [7:0] r;
    if (d < lo) begin
      r = lo;
    end else if (d > hi) begin
      r = hi;
    end else begin
      r = d;
    end
    return r;
  endfunction

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_HAND;
      target_q    <= '0;
      band_q      <= '0;
      cur_trip_q  <= 16'hFFFF;
      temp_trip_q <= 16'sh7FFF;
      floor_q     <= '0;
      ceil_q      <= 8'hFF;
    end else if (cfg_write_i) begin
      unique case (cfg_index_i)
        CFG_MODE:        mode_q      <= cfg_data_i[1:0];
        CFG_TARGET:      target_q    <= cfg_data_i;
        CFG_BAND:        band_q      <= cfg_data_i[14:0];
        CFG_CURRENT:     cur_trip_q  <= cfg_data_i;
        CFG_TEMPERATURE: temp_trip_q <= cfg_data_i;
        CFG_FLOOR:       floor_q     <= cfg_data_i[7:0];
        CFG_CEILING:     ceil_q      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Ramp goal and distance for a ramp transaction
  logic [7:0] rgoal;
  logic [7:0] rdiff;
  assign rgoal = clamp_duty(item_q.duty, floor_q, ceil_q);
  assign rdiff = (rgoal > duty_q) ? (rgoal - duty_q) : (duty_q - rgoal);

  assign sts_o.need_div = (item_q.kind == KIND_RAMP) && pump_q &&
                          (item_q.ramp_ms != '0) && (rdiff != '0);
  assign sts_o.div_last = (cnt_q == DivCntW'(DivSteps - 1));

  // Restoring divider: ramp_ms / rdiff, one quotient bit per cycle
  logic [8:0] trial;
  logic       fits;
  assign trial = {rem_q, quo_q[15]};
  assign fits  = (trial >= {1'b0, rdiff});

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= item_q.ramp_ms;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? 8'(trial - {1'b0, rdiff}) : trial[7:0];
      quo_q <= {quo_q[14:0], fits};
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.commit) begin
      result_q <= result_d;
    end
  end

  // Pressure band edges in 18-bit signed arithmetic
  logic signed [17:0] press_x;
  logic signed [17:0] band_hi;
  logic signed [17:0] band_lo;
  assign press_x = 18'(item_q.pressure);
  assign band_hi = 18'(target_q) + $signed({3'b000, band_q});
  assign band_lo = 18'(target_q) - $signed({3'b000, band_q});

  logic [15:0] iv;
  logic [15:0] ms_inc;
  logic [7:0]  step_duty;
  assign iv     = (quo_q < MIN_STEP_MS) ? MIN_STEP_MS : quo_q;
  assign ms_inc = ms_q + 16'd1;

  // Next state of the controller for the held transaction
  always_comb begin
    cause_e     cause;
    logic       pid;
    logic       refused;
    logic       on_req;
    logic [7:0] duty_req;
    logic       drive;

    pump_d     = pump_q;
    valve_d    = valve_q;
    duty_d     = duty_q;
    main_d     = main_q;
    emerg_d    = emerg_q;
    busy_d     = busy_q;
    goal_d     = goal_q;
    rising_d   = rising_q;
    interval_d = interval_q;
    ms_d       = ms_q;
    cause      = CAUSE_NONE;
    pid        = 1'b0;
    refused    = 1'b0;
    on_req     = 1'b0;
    duty_req   = '0;
    drive      = 1'b0;
    step_duty  = rising_q ? (duty_q + 8'd1) : (duty_q - 8'd1);

    unique case (item_q.kind)
      KIND_SAMPLE: begin
        if (item_q.estop) begin
          cause = CAUSE_ESTOP;
        end else if (item_q.current_ma > cur_trip_q) begin
          cause = CAUSE_OVERI;
        end else if (item_q.temperature > temp_trip_q) begin
          cause = CAUSE_OVERT;
        end
        if (cause != CAUSE_NONE) begin
          pump_d  = 1'b0;
          duty_d  = '0;
          main_d  = 1'b0;
          busy_d  = 1'b0;
          valve_d = 1'b0;
          emerg_d = 1'b1;
          pid     = (mode_q == MODE_LOOP);
        end else if (mode_q == MODE_HYST) begin
          if (press_x > band_hi) begin
            if (!pump_q) begin
              drive    = 1'b1;
              on_req   = 1'b1;
              duty_req = AUTO_DUTY;
            end
          end else if (press_x < band_lo) begin
            if (pump_q) begin
              drive = 1'b1;
            end
          end
        end
      end
      KIND_PUMP: begin
        drive    = 1'b1;
        on_req   = item_q.enable;
        duty_req = item_q.duty;
      end
      KIND_VALVE: begin
        if (item_q.enable && pump_q) begin
          refused = 1'b1;
        end else begin
          valve_d = item_q.enable;
        end
      end
      KIND_RAMP: begin
        if (!pump_q) begin
          refused = 1'b1;
        end else if ((item_q.ramp_ms == '0) || (rdiff == '0)) begin
          duty_d = rgoal;
          busy_d = 1'b0;
        end else begin
          interval_d = iv;
          goal_d     = rgoal;
          rising_d   = rgoal > duty_q;
          ms_d       = '0;
          duty_d     = (rgoal > duty_q) ? (duty_q + 8'd1) : (duty_q - 8'd1);
          busy_d     = (duty_d != rgoal);
        end
      end
      KIND_TICK: begin
        if (busy_q) begin
          ms_d = ms_inc;
          if (ms_inc >= interval_q) begin
            ms_d   = '0;
            duty_d = step_duty;
            busy_d = (step_duty != goal_q);
          end
        end
      end
      default: ;
    endcase

    // Pump drive with valve interlock
    if (drive) begin
      refused = on_req && valve_q;
      pump_d  = on_req && !valve_q;
      duty_d  = pump_d ? clamp_duty(duty_req, floor_q, ceil_q) : 8'd0;
      main_d  = pump_d;
      busy_d  = 1'b0;
    end

    result_d.pump_on          = pump_d;
    result_d.pump_duty        = duty_d;
    result_d.valve_on         = valve_d;
    result_d.main_supply      = main_d;
    result_d.emergency_supply = emerg_d;
    result_d.shutdown_cause   = cause;
    result_d.pid_reset        = pid;
    result_d.refused          = refused;
  end

  // State update on commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pump_q     <= 1'b0;
      valve_q    <= 1'b0;
      duty_q     <= '0;
      main_q     <= 1'b0;
      emerg_q    <= 1'b0;
      busy_q     <= 1'b0;
      goal_q     <= '0;
      rising_q   <= 1'b0;
      interval_q <= '0;
      ms_q       <= '0;
    end else if (cmd_i.commit) begin
      pump_q     <= pump_d;
      valve_q    <= valve_d;
      duty_q     <= duty_d;
      main_q     <= main_d;
      emerg_q    <= emerg_d;
      busy_q     <= busy_d;
      goal_q     <= goal_d;
      rising_q   <= rising_d;
      interval_q <= interval_d;
      ms_q       <= ms_d;
    end
  end

  assign result_o = result_q;

endmodule

// ===== sv/pump_valve_safety_controller_unit.sv =====
// Pump and valve safety controller.
// Channels: item_i takes one transaction per sensor sample, pump command,
// valve command, ramp command or millisecond tick; result_o returns exactly
// one result transaction per item with the pump, valve and supply state
// after that item. cfg_i writes the seven configuration registers by index
// and is always ready; write it only while no item is in flight.
// Sequence: an accepted item is captured, evaluated and then committed to
// the result register. A ramp command that actually starts a ramp first runs
// the serial interval divider (one quotient bit per cycle) before commit.
// Items do not overlap: a new item is taken only once the last is through;
// item_i reopens once the result sits in the output register.
// Stall: the result register holds its transaction until taken; an item
// finished while it is still full waits in the controller and item_i
// stays low until the slot drains.
// Reset (rst_ni low, async): all outputs off, emergency line released,
// registers back to their defaults, no result pending.
module pump_valve_safety_controller_unit (
  input logic        clk_i,
  input logic        rst_ni,
  pvsc_in_if.sink    item_i,
  pvsc_out_if.source result_o,
  pvsc_cfg_if.sink   cfg_i
);
  import pvsc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_i.ready = 1'b1;

  pvsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pvsc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .item_i      (item_i.data),
    .cfg_write_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .result_o    (result_o.data)
  );

endmodule

// ===== dv/tb_pump_valve_safety_controller_unit.sv =====
`timescale 1ns / 1ps

module tb_pump_valve_safety_controller_unit;
  import pvsc_pkg::*;

  // Control law constants
  localparam logic [7:0]  DUTY_AUTO_ON = 8'd200;
  localparam int unsigned STEP_MIN_MS  = 10;

  logic clk_i;
  logic rst_ni;

  pvsc_in_if  item_if ();
  pvsc_out_if result_if ();
  pvsc_cfg_if cfg_if ();

  pump_valve_safety_controller_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(result_if),
    .cfg_i   (cfg_if)
  );

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Shadow registers
  mode_e              cfg_mode   = MODE_HAND;
  logic signed [15:0] cfg_target = '0;
  logic [14:0]        cfg_band   = '0;
  logic [15:0]        cfg_itrip  = 16'hFFFF;
  logic signed [15:0] cfg_ttrip  = 16'sh7FFF;
  logic [7:0]         cfg_floor  = 8'd0;
  logic [7:0]         cfg_ceil   = 8'd255;

  // Predicted plant state
  logic        pump_q     = 1'b0;
  logic        valve_q    = 1'b0;
  logic [7:0]  duty_q     = 8'd0;
  logic        main_q     = 1'b0;
  logic        emerg_q    = 1'b0;
  logic        ramp_act_q = 1'b0;
  logic [7:0]  ramp_tgt_q = 8'd0;
  logic        ramp_up_q  = 1'b0;
  logic [15:0] ramp_iv_q  = 16'd0;
  logic [15:0] ramp_ms_q  = 16'd0;

  in_item_t  items_to_send[$];
  out_item_t status_due[$];

  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_go        = 1'b0;
  logic        hold_off       = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] limit_duty(logic [7:0] d);
    if (d < cfg_floor) return cfg_floor;
    if (d > cfg_ceil) return cfg_ceil;
    return d;
  endfunction

  // Returns 1 when the interlock kept the pump off
  function automatic logic set_pump(logic on, logic [7:0] d);
    logic forced;
    forced     = on && valve_q;
    pump_q     = on && !valve_q;
    duty_q     = pump_q ? limit_duty(d) : 8'd0;
    main_q     = pump_q;
    ramp_act_q = 1'b0;
    return forced;
  endfunction

  function automatic void advance_ramp();
    duty_q = ramp_up_q ? duty_q + 8'd1 : duty_q - 8'd1;
    if (duty_q == ramp_tgt_q) ramp_act_q = 1'b0;
  endfunction

  function automatic out_item_t next_status(in_item_t it);
    out_item_t   r;
    cause_e      cause;
    logic        pulse;
    logic        refused;
    int          p;
    int          hi;
    int          lo;
    logic [7:0]  goal;
    logic [7:0]  diff;
    int unsigned iv;
    cause   = CAUSE_NONE;
    pulse   = 1'b0;
    refused = 1'b0;
    case (it.kind)
      KIND_SAMPLE: begin
        if (it.estop) cause = CAUSE_ESTOP;
        else if (it.current_ma > cfg_itrip) cause = CAUSE_OVERI;
        else if ($signed(it.temperature) > cfg_ttrip) cause = CAUSE_OVERT;
        if (cause != CAUSE_NONE) begin
          // shutdown: everything off, emergency line latched
          void'(set_pump(1'b0, 8'd0));
          valve_q = 1'b0;
          emerg_q = 1'b1;
          pulse   = (cfg_mode == MODE_LOOP);
        end else if (cfg_mode == MODE_HYST) begin
          p  = $signed(it.pressure);
          hi = int'(cfg_target) + int'(cfg_band);
          lo = int'(cfg_target) - int'(cfg_band);
          if (p > hi) begin
            if (!pump_q) refused = set_pump(1'b1, DUTY_AUTO_ON);
          end else if (p < lo) begin
            if (pump_q) void'(set_pump(1'b0, 8'd0));
          end
        end
      end
      KIND_PUMP: refused = set_pump(it.enable, it.duty);
      KIND_VALVE: begin
        if (it.enable && pump_q) refused = 1'b1;
        else valve_q = it.enable;
      end
      KIND_RAMP: begin
        if (!pump_q) begin
          refused = 1'b1;
        end else begin
          goal = limit_duty(it.duty);
          diff = (goal > duty_q) ? goal - duty_q : duty_q - goal;
          if (it.ramp_ms == 16'd0 || diff == 8'd0) begin
            duty_q     = goal;
            ramp_act_q = 1'b0;
          end else begin
            iv = it.ramp_ms / diff;
            if (iv < STEP_MIN_MS) iv = STEP_MIN_MS;
            ramp_iv_q  = iv[15:0];
            ramp_tgt_q = goal;
            ramp_up_q  = goal > duty_q;
            ramp_ms_q  = 16'd0;
            ramp_act_q = 1'b1;
            advance_ramp();
          end
        end
      end
      KIND_TICK: begin
        if (ramp_act_q) begin
          ramp_ms_q = ramp_ms_q + 16'd1;
          if (ramp_ms_q >= ramp_iv_q) begin
            ramp_ms_q = 16'd0;
            advance_ramp();
          end
        end
      end
      default: ;
    endcase
    r.pump_on          = pump_q;
    r.pump_duty        = duty_q;
    r.valve_on         = valve_q;
    r.main_supply      = main_q;
    r.emergency_supply = emerg_q;
    r.shutdown_cause   = cause;
    r.pid_reset        = pulse;
    r.refused          = refused;
    return r;
  endfunction

  function automatic void store_cfg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    case (idx)
      CFG_MODE:        cfg_mode   = mode_e'(val[1:0]);
      CFG_TARGET:      cfg_target = val;
      CFG_BAND:        cfg_band   = val[14:0];
      CFG_CURRENT:     cfg_itrip  = val;
      CFG_TEMPERATURE: cfg_ttrip  = val;
      CFG_FLOOR:       cfg_floor  = val[7:0];
      CFG_CEILING:     cfg_ceil   = val[7:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: items from the send queue, random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (item_if.valid && item_if.ready) status_due.push_back(next_status(item_if.data));
      if (!item_if.valid || item_if.ready) begin
        if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item_if.valid <= 1'b1;
          item_if.data  <= items_to_send.pop_front();
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) begin
        got = result_if.data;
        if (status_due.size() == 0) begin
          report_mismatch("result transaction with no expectation pending");
        end else begin
          want = status_due.pop_front();
          check_field("pump_on", got.pump_on, want.pump_on);
          check_field("pump_duty", got.pump_duty, want.pump_duty);
          check_field("valve_on", got.valve_on, want.valve_on);
          check_field("main_supply", got.main_supply, want.main_supply);
          check_field("emergency_supply", got.emergency_supply, want.emergency_supply);
          check_field("shutdown_cause", got.shutdown_cause, want.shutdown_cause);
          check_field("pid_reset", got.pid_reset, want.pid_reset);
          check_field("refused", got.refused, want.refused);
        end
      end
      result_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_item_t blank_item(logic [2:0] k);
    logic [95:0] bits;
    in_item_t    it;
    bits    = {$urandom, $urandom, $urandom};
    it      = bits[$bits(in_item_t)-1:0];
    it.kind = k;
    return it;
  endfunction

  function automatic in_item_t sample_item(logic [15:0] p, logic [15:0] i, logic [15:0] t,
                                           logic e);
    in_item_t it;
    it             = blank_item(KIND_SAMPLE);
    it.pressure    = p;
    it.current_ma  = i;
    it.temperature = t;
    it.estop       = e;
    return it;
  endfunction

  function automatic in_item_t cmd_item(kind_e k, logic en, logic [7:0] d, logic [15:0] ms);
    in_item_t it;
    it         = blank_item(k);
    it.enable  = en;
    it.duty    = d;
    it.ramp_ms = ms;
    return it;
  endfunction

  // Pressure spread around the present set point
  function automatic logic [15:0] near_target();
    int span;
    int p;
    span = 2 * int'(cfg_band) + 10;
    p    = int'(cfg_target) + int'($urandom_range(0, 2 * span)) - span;
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return p[15:0];
  endfunction

  function automatic in_item_t calm_sample();
    return sample_item(near_target(), 16'($urandom_range(0, 2500)),
                       16'(int'($urandom_range(0, 1200)) - 400), 1'b0);
  endfunction

  function automatic logic [15:0] ramp_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return 16'd0;
    if (r < 90) return 16'($urandom_range(1, 600));
    return 16'($urandom);
  endfunction

  task automatic queue_random(int n);
    int          added;
    int unsigned r;
    int unsigned ticks;
    added = 0;
    while (added < n) begin
      r = $urandom_range(99);
      if (r < 35) begin
        // well-formed ramp: valve shut, pump on, ramp, then a run of ticks
        items_to_send.push_back(cmd_item(KIND_VALVE, 1'b0, 8'($urandom), 16'($urandom)));
        items_to_send.push_back(cmd_item(KIND_PUMP, 1'b1, 8'($urandom), 16'($urandom)));
        items_to_send.push_back(cmd_item(KIND_RAMP, 1'b1, 8'($urandom), ramp_length()));
        ticks = $urandom_range(5, 60);
        repeat (ticks) begin
          if ($urandom_range(9) == 0) items_to_send.push_back(calm_sample());
          else items_to_send.push_back(blank_item(KIND_TICK));
        end
        added += 3 + ticks;
      end else if (r < 55) begin
        items_to_send.push_back(calm_sample());
        added++;
      end else if (r < 62) begin
        items_to_send.push_back(sample_item(16'($urandom), 16'($urandom), 16'($urandom),
                                            $urandom_range(3) == 0));
        added++;
      end else if (r < 72) begin
        items_to_send.push_back(cmd_item(KIND_PUMP, $urandom_range(3) != 0, 8'($urandom),
                                         16'($urandom)));
        added++;
      end else if (r < 82) begin
        items_to_send.push_back(blank_item(KIND_VALVE));
        added++;
      end else if (r < 88) begin
        items_to_send.push_back(cmd_item(KIND_RAMP, 1'b1, 8'($urandom), ramp_length()));
        added++;
      end else if (r < 96) begin
        items_to_send.push_back(blank_item(KIND_TICK));
        added++;
      end else begin
        // unused kinds; not counted
        items_to_send.push_back(blank_item(3'($urandom_range(5, 7))));
      end
    end
  endtask

  // One register write; valid stays up for the caller to lower
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    store_cfg(idx, val);
  endtask

  task automatic set_config(mode_e m, logic [15:0] target, logic [15:0] band,
                            logic [15:0] itrip, logic [15:0] ttrip,
                            logic [7:0] floor_v, logic [7:0] ceil_v);
    write_reg(CFG_MODE, 16'(m));
    write_reg(CFG_TARGET, target);
    write_reg(CFG_BAND, band);
    write_reg(CFG_CURRENT, itrip);
    write_reg(CFG_TEMPERATURE, ttrip);
    write_reg(CFG_FLOOR, 16'(floor_v));
    write_reg(CFG_CEILING, 16'(ceil_v));
    cfg_if.valid <= 1'b0;
  endtask

  // Block is idle once nothing is queued, offered or outstanding
  task automatic wait_drained();
    do @(posedge clk_i);
    while (items_to_send.size() != 0 || item_if.valid || status_due.size() != 0);
  endtask

  task automatic run_phase(mode_e m, logic [15:0] target, logic [15:0] band,
                           logic [15:0] itrip, logic [15:0] ttrip,
                           logic [7:0] floor_v, logic [7:0] ceil_v,
                           int unsigned idle_pct, int unsigned stall_pct, bit hold, int n);
    wait_drained();
    repeat (5) @(posedge clk_i);
    set_config(m, target, band, itrip, ttrip, floor_v, ceil_v);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (hold) hold_go = 1'b1;
    queue_random(n);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int tick_n;
    rst_ni          = 1'b0;
    item_if.valid   = 1'b0;
    item_if.data    = '0;
    result_if.ready = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: interlock, hysteresis, clamping, ramps, each shutdown cause
    set_config(MODE_HYST, 16'd1000, 16'd50, 16'd3000, 16'd800, 8'd20, 8'd220);
    items_to_send.push_back(cmd_item(KIND_VALVE, 1'b1, 8'd0, 16'd0));
    items_to_send.push_back(cmd_item(KIND_PUMP, 1'b1, 8'd255, 16'd0));      // interlock
    items_to_send.push_back(sample_item(16'd1100, 16'd0, 16'd0, 1'b0));     // auto, valve open
    items_to_send.push_back(cmd_item(KIND_VALVE, 1'b0, 8'd0, 16'd0));
    items_to_send.push_back(sample_item(16'h7FFF, 16'd3000, 16'd800, 1'b0)); // at trip limits
    items_to_send.push_back(cmd_item(KIND_VALVE, 1'b1, 8'd0, 16'd0));      // pump runs
    items_to_send.push_back(sample_item(16'h8000, 16'd0, 16'h8000, 1'b0));  // auto off
    items_to_send.push_back(cmd_item(KIND_PUMP, 1'b1, 8'd0, 16'd0));       // floor clamp
    items_to_send.push_back(cmd_item(KIND_RAMP, 1'b1, 8'd255, 16'd0));     // immediate
    items_to_send.push_back(cmd_item(KIND_RAMP, 1'b1, 8'd220, 16'hFFFF));  // zero diff
    items_to_send.push_back(cmd_item(KIND_RAMP, 1'b1, 8'd0, 16'd100));     // minimum interval
    for (tick_n = 0; tick_n < 10; tick_n++) items_to_send.push_back(blank_item(KIND_TICK));
    items_to_send.push_back(cmd_item(KIND_PUMP, 1'b0, 8'd0, 16'd0));       // cancels ramp
    items_to_send.push_back(cmd_item(KIND_RAMP, 1'b1, 8'd100, 16'd50));    // pump idle
    items_to_send.push_back(sample_item(16'd0, 16'd0, 16'd0, 1'b1));       // estop
    items_to_send.push_back(cmd_item(KIND_PUMP, 1'b1, 8'd100, 16'd0));
    items_to_send.push_back(sample_item(16'd0, 16'hFFFF, 16'd0, 1'b0));    // overcurrent
    items_to_send.push_back(sample_item(16'd0, 16'd0, 16'h7FFF, 1'b0));    // overtemperature
    items_to_send.push_back(blank_item(3'd7));

    // Random phases over several register settings and handshake patterns
    run_phase(MODE_HYST, -16'sd200, 16'd0, 16'd40000, 16'd900, 8'd0, 8'd255,
              0, 0, 1'b0, 275);
    run_phase(MODE_LOOP, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h7FFF, 8'd255, 8'd0,
              53, 0, 1'b0, 275);
    run_phase(MODE_HAND, 16'h8000, 16'h7FFF, 16'd0, 16'h8000, 8'd0, 8'd255,
              0, 53, 1'b0, 275);
    run_phase(MODE_SPARE, 16'd0, 16'd100, 16'd5000, 16'd1500, 8'd30, 8'd200,
              16, 16, 1'b0, 275);
    run_phase(MODE_HYST, 16'd500, 16'd200, 16'hFFFF, 16'h7FFF, 8'd0, 8'd255,
              0, 0, 1'b1, 275);
    run_phase(MODE_LOOP, 16'd100, 16'd10, 16'd2000, 16'd700, 8'd50, 8'd50,
              16, 53, 1'b0, 275);

    wait_drained();
    repeat (25) @(posedge clk_i);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
